// ----- sv/sorted_range_floor_lookup_assert.svh -----
// assertion macros for the sorted range floor lookup checker
// expects clk and rst_n in scope where used
`ifndef SORTED_RANGE_FLOOR_LOOKUP_ASSERT_SVH
`define SORTED_RANGE_FLOOR_LOOKUP_ASSERT_SVH

// same-cycle implication
`define SRFL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srfl assertion failed");

// next-cycle implication
`define SRFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srfl assertion failed");

`endif

// ----- sv/srfl_pkg.sv -----
// shared types and constants for the sorted range floor lookup
// no dependencies
package srfl_pkg;

  localparam int DEPTH    = 4096;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CHROM_W  = 8;
  localparam int POS_W    = 32;
  localparam int KEY_W    = CHROM_W + POS_W;
  localparam int SCORE_W  = 32;
  localparam int STATUS_W = 3;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_APPENDED = 3'd0,
    ST_ORDER    = 3'd1,
    ST_FULL     = 3'd2,
    ST_FOUND    = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [SCORE_W-1:0]   score;
  } res_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    addr;
    logic [KEY_W-1:0]     wkey;
    logic [SCORE_W-1:0]   wscore;
  } mem_req_t;

endpackage

// ----- sv/srfl_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module srfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/srfl_ctrl.sv -----
// append and binary search sequencer driving the key and score memories
// depends on srfl_pkg
module srfl_ctrl
  import srfl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  op_t                 in_op,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [SCORE_W-1:0]  in_score,
  output mem_req_t            mem_req,
  input  logic [KEY_W-1:0]    key_rdata,
  input  logic [SCORE_W-1:0]  score_rdata,
  output logic                res_valid,
  input  logic                res_ready,
  output res_t                res
);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [KEY_W-1:0]     last_key_r, last_key_nxt;
  logic [KEY_W-1:0]     q_r, q_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     hi_r, hi_nxt;
  logic [CNT_W-1:0]     mid_r, mid_nxt;
  logic                 pred_ok_r, pred_ok_nxt;
  logic [SCORE_W-1:0]   pred_score_r, pred_score_nxt;
  res_t                 res_r, res_nxt;

  logic                 accept;
  logic                 app_order;
  logic                 app_full;
  logic                 app_ok;
  logic [CNT_W-1:0]     mid_c;
  logic                 cmp_eq;
  logic                 cmp_lt;
  logic [CNT_W-1:0]     cmp_lo;
  logic [CNT_W-1:0]     cmp_hi;

  assign accept    = in_valid && in_ready;
  assign app_order = (count_r != '0) && (in_key <= last_key_r);
  assign app_full  = (count_r == CNT_W'(DEPTH));
  assign app_ok    = !app_order && !app_full;
  assign mid_c     = lo_r + ((hi_r - lo_r) >> 1);
  assign cmp_eq    = (key_rdata == q_r);
  assign cmp_lt    = (key_rdata < q_r);
  assign cmp_lo    = cmp_lt ? (mid_r + CNT_W'(1)) : lo_r;
  assign cmp_hi    = cmp_lt ? hi_r : mid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_LOOKUP && count_r != '0) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (cmp_eq || !(cmp_lo < cmp_hi)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = (state_r == S_IDLE);
    res_valid      = (state_r == S_DONE);
    res            = res_r;
    mem_req.we     = accept && (in_op == OP_APPEND) && app_ok;
    mem_req.addr   = mem_req.we ? count_r[ADDR_W-1:0] : mid_c[ADDR_W-1:0];
    mem_req.wkey   = in_key;
    mem_req.wscore = in_score;
  end

  // datapath next values
  always_comb begin
    count_nxt      = count_r;
    last_key_nxt   = last_key_r;
    q_nxt          = q_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    pred_ok_nxt    = pred_ok_r;
    pred_score_nxt = pred_score_r;
    res_nxt        = res_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          q_nxt          = in_key;
          lo_nxt         = '0;
          hi_nxt         = count_r;
          pred_ok_nxt    = 1'b0;
          pred_score_nxt = '0;
          res_nxt.score  = '0;
          if (in_op == OP_APPEND) begin
            if (app_order) begin
              res_nxt.status = ST_ORDER;
            end else if (app_full) begin
              res_nxt.status = ST_FULL;
            end else begin
              res_nxt.status = ST_APPENDED;
              count_nxt      = count_r + CNT_W'(1);
              last_key_nxt   = in_key;
            end
          end else begin
            res_nxt.status = ST_UNKNOWN;
          end
        end
      end
      S_READ: begin
        mid_nxt = mid_c;
      end
      S_CMP: begin
        lo_nxt = cmp_lo;
        hi_nxt = cmp_hi;
        if (cmp_lt) begin
          pred_ok_nxt    = (key_rdata[KEY_W-1:POS_W] == q_r[KEY_W-1:POS_W]);
          pred_score_nxt = score_rdata;
        end
        if (cmp_eq) begin
          res_nxt.status = ST_FOUND;
          res_nxt.score  = score_rdata;
        end else if (!(cmp_lo < cmp_hi)) begin
          // predecessor is the last probe that moved lo up, or this one
          if (cmp_lt ? (key_rdata[KEY_W-1:POS_W] == q_r[KEY_W-1:POS_W]) : pred_ok_r) begin
            res_nxt.status = ST_FOUND;
            res_nxt.score  = cmp_lt ? score_rdata : pred_score_r;
          end else begin
            res_nxt.status = ST_UNKNOWN;
            res_nxt.score  = '0;
          end
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_key_r   <= last_key_nxt;
    q_r          <= q_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    pred_ok_r    <= pred_ok_nxt;
    pred_score_r <= pred_score_nxt;
    res_r        <= res_nxt;
  end

endmodule

// ----- sv/srfl_obuf.sv -----
// output register between the sequencer and the result channel
// depends on srfl_pkg
module srfl_obuf
  import srfl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  res_valid,
  output logic  res_ready,
  input  res_t  res,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  logic valid_r, valid_nxt;
  res_t data_r, data_nxt;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = data_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (res_valid && res_ready) begin
      valid_nxt = 1'b1;
      data_nxt  = res;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ----- sv/sorted_range_floor_lookup.sv -----
// Sorted range table with floor lookup. Keys are {chromosome_id, position} and must be
// appended in strictly rising order; a lookup returns the score of the exact key or of the
// closest lower key on the same chromosome. One item is worked on at a time. An append
// goes from the idle state straight to the done state. A lookup runs a binary search in
// which each probe passes a read state, then a compare state on the registered key read,
// with at most ceil(log2(entries + 1)) probes for a table of up to 4096 entries.
// The finished result sits in an output register so the next input can be taken while it
// waits. No clearing pass is needed after reset; only stored entries are ever read.
// depends on srfl_pkg, srfl_ctrl, srfl_ram, srfl_obuf
module sorted_range_floor_lookup
  import srfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // chromosome_id[7:0], position[39:8], new_score[71:40]
  input  logic [0:0]  in_tuser,   // opcode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[2:0], found_score[34:3], zero fill[39:35]
);

  mem_req_t           mem_req;
  logic [KEY_W-1:0]   key_rdata;
  logic [SCORE_W-1:0] score_rdata;
  logic               res_valid;
  logic               res_ready;
  res_t               res;
  res_t               out_res;
  logic [KEY_W-1:0]   in_key;

  assign in_key = {in_tdata[7:0], in_tdata[39:8]};

  srfl_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (op_t'(in_tuser[0])),
    .in_key      (in_key),
    .in_score    (in_tdata[71:40]),
    .mem_req     (mem_req),
    .key_rdata   (key_rdata),
    .score_rdata (score_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  srfl_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wkey),
    .rdata (key_rdata)
  );

  srfl_ram #(.WIDTH(SCORE_W), .DEPTH(DEPTH)) u_score_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wscore),
    .rdata (score_rdata)
  );

  srfl_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {5'b0, out_res.score, out_res.status};

endmodule

// ----- sv/srfl_checker.sv -----
// port-level checks for the sorted range floor lookup, bound to the top level
// depends on srfl_pkg and sorted_range_floor_lookup_assert.svh
`include "sorted_range_floor_lookup_assert.svh"

module srfl_checker
  import srfl_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [71:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  logic in_xfer;
  logic out_stall;
  logic out_not_found;

  assign in_xfer       = in_tvalid && in_tready;
  assign out_stall     = out_tvalid && !out_tready;
  assign out_not_found = out_tvalid && (out_tdata[2:0] != 3'(ST_FOUND));

  // one item in flight: no second transfer right after the first
  `SRFL_ASSERT_NEXT(a_one_in_flight, in_xfer, !in_tready)
  // appends and misses carry a zero score
  `SRFL_ASSERT_NOW(a_zero_score, out_not_found, out_tdata[34:3] == '0)
  // fill bits stay zero
  `SRFL_ASSERT_NOW(a_fill_zero, out_tvalid, out_tdata[39:35] == '0)
  // a stalled result holds
  `SRFL_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata))

endmodule

bind sorted_range_floor_lookup srfl_checker u_srfl_checker (.*);

// ----- tb/sv/tb.sv -----
// self-checking testbench for sorted_range_floor_lookup: appends, rejects, floor lookups
// drives both stream ports with random idling and checks each result against its own table copy
// depends on srfl_pkg and the sorted_range_floor_lookup rtl
module tb;
  import srfl_pkg::*;

  class range_table_checker;
    logic [KEY_W-1:0]   keys   [DEPTH];
    logic [SCORE_W-1:0] scores [DEPTH];
    int unsigned        entries;
    res_t               pending_answers[$];
    int                 errors;
    int                 n_status[8];

    function new();
      entries = 0;
      errors  = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function void note_request(op_t op, logic [KEY_W-1:0] key, logic [SCORE_W-1:0] score);
      res_t answer;
      int   lo;
      int   hi;
      int   mid;
      answer.status = ST_UNKNOWN;
      answer.score  = '0;
      if (op == OP_APPEND) begin
        if (entries > 0 && key <= keys[entries-1]) begin
          answer.status = ST_ORDER;
        end else if (entries == DEPTH) begin
          answer.status = ST_FULL;
        end else begin
          keys[entries]   = key;
          scores[entries] = score;
          entries++;
          answer.status = ST_APPENDED;
        end
      end else begin
        // lo ends as the number of stored keys not above the query
        lo = 0;
        hi = entries;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (keys[mid] <= key) lo = mid + 1;
          else hi = mid;
        end
        if (lo > 0 && keys[lo-1][KEY_W-1:POS_W] == key[KEY_W-1:POS_W]) begin
          answer.status = ST_FOUND;
          answer.score  = scores[lo-1];
        end
      end
      pending_answers = {pending_answers, answer};
    endfunction

    function void check_answer(logic [39:0] word);
      res_t               want;
      logic [2:0]         got_status;
      logic [SCORE_W-1:0] got_score;
      got_status = word[2:0];
      got_score  = word[34:3];
      n_status[got_status]++;
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d score %h", got_status, got_score);
      end else begin
        want = pending_answers.pop_front();
        if (want.status !== status_t'(got_status) || want.score !== got_score) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: status exp %0d got %0d, score exp %h got %h",
                     want.status, got_status, want.score, got_score);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // chromosome_id[7:0], position[39:8], new_score[71:40]
  logic [0:0]  in_tuser;   // opcode[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;  // status[2:0], found_score[34:3], zero fill[39:35]

  int send_idle_pct;
  int recv_idle_pct;
  range_table_checker table_chk;

  sorted_range_floor_lookup dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) table_chk.check_answer(out_tdata);
  end

  task automatic send_item(input op_t op, input logic [KEY_W-1:0] key,
                           input logic [SCORE_W-1:0] score);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {score, key[POS_W-1:0], key[KEY_W-1:POS_W]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    table_chk.note_request(op, key, score);
  endtask

  function automatic logic [KEY_W-1:0] last_key();
    return (table_chk.entries > 0) ? table_chk.keys[table_chk.entries-1] : '0;
  endfunction

  function automatic logic [KEY_W-1:0] stored_key();
    return table_chk.keys[$urandom_range(0, table_chk.entries - 1)];
  endfunction

  // strictly above the last key, leaving room for a full table
  function automatic logic [KEY_W-1:0] next_key();
    logic [CHROM_W-1:0] chrom;
    logic [POS_W-1:0]   pos;
    chrom = CHROM_W'(last_key() >> POS_W);
    pos   = POS_W'(last_key());
    if (table_chk.entries == 0) return {8'd0, 32'($urandom_range(0, 32'hFFFF))};
    if (($urandom_range(0, 15) == 0 && chrom < 200) || pos > 32'hFFF0_0000) begin
      chrom = CHROM_W'(chrom + 1 + ((chrom < 200) ? $urandom_range(0, 2) : 0));
      pos   = $urandom_range(0, 32'hEFFF_FFFF);
    end else begin
      pos = POS_W'(pos + (($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 32'h0001_0000)));
    end
    return {chrom, pos};
  endfunction

  function automatic logic [KEY_W-1:0] stale_key();
    if (table_chk.entries == 0) return next_key();
    case ($urandom_range(0, 2))
      0:       return last_key();
      1:       return stored_key();
      default: return last_key() - $urandom_range(1, 1000);
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] query_key();
    logic [KEY_W-1:0] k;
    if (table_chk.entries == 0) return {8'($urandom_range(0, 255)), 32'($urandom)};
    k = stored_key();
    case ($urandom_range(0, 6))
      0:       return k;
      1:       return k + $urandom_range(1, 3);
      2:       return k - $urandom_range(1, 3);
      3:       return {k[KEY_W-1:POS_W], 32'($urandom)};
      4:       return {CHROM_W'(last_key() >> POS_W), 32'hFFFF_FFFF};
      5:       return {table_chk.keys[0][KEY_W-1:POS_W], 32'h0};
      default: return {8'($urandom_range(0, 255)), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [SCORE_W-1:0] any_score();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) send_item(OP_APPEND, next_key(), any_score());
    else if (pick < 45) send_item(OP_APPEND, stale_key(), any_score());
    else send_item(OP_LOOKUP, query_key(), $urandom);
  endtask

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    table_chk = new();
    send_idle_pct = 33;
    recv_idle_pct = 67;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_APPEND;
    in_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table
    send_item(OP_LOOKUP, {8'd0, 32'd0}, '1);
    send_item(OP_LOOKUP, {8'd255, 32'hFFFF_FFFF}, '0);
    // smallest key, then equal and lower keys
    send_item(OP_APPEND, {8'd0, 32'd0}, 32'h0);
    send_item(OP_APPEND, {8'd0, 32'd0}, 32'h1111_1111);
    send_item(OP_LOOKUP, {8'd0, 32'd0}, '0);
    send_item(OP_APPEND, {8'd0, 32'd100}, 32'hFFFF_FFFF);
    send_item(OP_APPEND, {8'd0, 32'd50}, 32'h2222_2222);
    // exact, floor, and past the last entry on the same chromosome
    send_item(OP_LOOKUP, {8'd0, 32'd100}, '0);
    send_item(OP_LOOKUP, {8'd0, 32'd99}, '0);
    send_item(OP_LOOKUP, {8'd0, 32'hFFFF_FFFF}, '0);
    send_item(OP_APPEND, {8'd3, 32'd1000}, 32'h1234_5678);
    // predecessor on another chromosome
    send_item(OP_LOOKUP, {8'd1, 32'd5}, '0);
    send_item(OP_LOOKUP, {8'd3, 32'd999}, '0);
    send_item(OP_LOOKUP, {8'd3, 32'd5000}, '0);
    send_item(OP_LOOKUP, {8'd255, 32'hFFFF_FFFF}, '1);
    send_item(OP_APPEND, {8'd3, 32'd2000}, 32'hA5A5_A5A5);
    send_item(OP_LOOKUP, {8'd3, 32'd1500}, '0);
    send_item(OP_LOOKUP, {8'd2, 32'hFFFF_FFFF}, '0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 67 : 0;
      recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 33 : 0;
      repeat (270) random_item();
    end
    in_tvalid <= 1'b0;

    while (table_chk.pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("results: %0d appended, %0d out of order, %0d table full, %0d found, %0d unknown",
             table_chk.n_status[ST_APPENDED], table_chk.n_status[ST_ORDER],
             table_chk.n_status[ST_FULL], table_chk.n_status[ST_FOUND],
             table_chk.n_status[ST_UNKNOWN]);
    $display("table reached %0d of %0d entries, %0d mismatches",
             table_chk.entries, DEPTH, table_chk.errors);
    if (table_chk.errors == 0 && table_chk.pending_answers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+sv
sv/srfl_pkg.sv
sv/srfl_ram.sv
sv/srfl_ctrl.sv
sv/srfl_obuf.sv
sv/sorted_range_floor_lookup.sv
sv/srfl_checker.sv
tb/sv/tb.sv
